// ===== design/hclb_pkg.sv =====
// ---------------------------------------------------------------------------
// hclb_pkg: shared definitions for the code length builder
// Action codes, configuration indexes, field widths and the engine result.
// ---------------------------------------------------------------------------
package hclb_pkg;

    localparam int DEF_MAX_SYMBOLS = 256;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_LIMIT       = 15;

    localparam int ACTION_W   = 2;
    localparam int SYMBOL_W   = 8;
    localparam int COUNT_W    = 16;
    localparam int LEN_W      = 4;
    localparam int LIMIT_W    = 4;
    localparam int ALPHA_W    = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;

    typedef struct packed {
        logic done;
        logic short_alpha;
    } hclb_result_t;

endpackage

// ===== design/hclb_engine.sv =====
// ---------------------------------------------------------------------------
// hclb_engine: build sequencer
// Sorts used symbols, merges the two queues, walks depths, clamps lengths
// and writes the length table, one memory access per step.
// ---------------------------------------------------------------------------
module hclb_engine #(
    parameter int MAX_SYMBOLS = hclb_pkg::DEF_MAX_SYMBOLS,
    parameter int COUNT_BITS  = hclb_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [hclb_pkg::LIMIT_W-1:0]        limit,
    input  logic [$clog2(MAX_SYMBOLS):0]        span,
    output logic [$clog2(MAX_SYMBOLS)-1:0]      cnt_raddr,
    input  logic [((COUNT_BITS < 16) ? COUNT_BITS : 16)-1:0] cnt_data,
    output logic                                len_we,
    output logic [$clog2(MAX_SYMBOLS)-1:0]      len_addr,
    output logic [hclb_pkg::LEN_W-1:0]          len_data,
    output hclb_pkg::hclb_result_t              result
);
    import hclb_pkg::*;

    localparam int SYM_W      = $clog2(MAX_SYMBOLS);
    localparam int CW         = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int NODE_SLOTS = 2 * MAX_SYMBOLS;
    localparam int NODE_W     = SYM_W + 1;
    localparam int TOT_W      = SYM_W + 2;
    localparam int CNT_W      = SYM_W + 1;
    localparam int FREQ_W     = CW + SYM_W + 1;
    localparam int DEP_W      = (SYM_W + 1 > 4) ? SYM_W + 1 : 5;
    localparam int SUM_W      = SYM_W + 17;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_G_RD   = 5'd1;
    localparam logic [4:0] S_G_CHK  = 5'd2;
    localparam logic [4:0] S_G_POS  = 5'd3;
    localparam logic [4:0] S_G_CMP  = 5'd4;
    localparam logic [4:0] S_T_INIT = 5'd5;
    localparam logic [4:0] S_M_CHK  = 5'd6;
    localparam logic [4:0] S_M_RD   = 5'd7;
    localparam logic [4:0] S_M_PICK = 5'd8;
    localparam logic [4:0] S_D_ROOT = 5'd9;
    localparam logic [4:0] S_D_RD   = 5'd10;
    localparam logic [4:0] S_D_W0   = 5'd11;
    localparam logic [4:0] S_D_W1   = 5'd12;
    localparam logic [4:0] S_C_RD0  = 5'd13;
    localparam logic [4:0] S_C_CHK0 = 5'd14;
    localparam logic [4:0] S_K1_RD  = 5'd15;
    localparam logic [4:0] S_K1_W   = 5'd16;
    localparam logic [4:0] S_K2_CHK = 5'd17;
    localparam logic [4:0] S_K2_LD  = 5'd18;
    localparam logic [4:0] S_K2_RUN = 5'd19;
    localparam logic [4:0] S_K3_RD  = 5'd20;
    localparam logic [4:0] S_K3_LD  = 5'd21;
    localparam logic [4:0] S_K3_RUN = 5'd22;
    localparam logic [4:0] S_O_RD   = 5'd23;
    localparam logic [4:0] S_O_W    = 5'd24;
    localparam logic [4:0] S_DONE   = 5'd25;

    // scratch memories
    logic [FREQ_W-1:0]   freq_mem  [NODE_SLOTS];
    logic [2*NODE_W-1:0] child_mem [NODE_SLOTS];
    logic [DEP_W-1:0]    level_mem [NODE_SLOTS];
    logic [SYM_W-1:0]    sym_mem   [MAX_SYMBOLS];

    logic [4:0]        state_reg, state_next;
    logic [CNT_W-1:0]  s_reg, s_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CW-1:0]     cur_c_reg, cur_c_next;
    logic [CNT_W-1:0]  li_reg, li_next;
    logic [TOT_W-1:0]  ti_reg, ti_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              phase_reg, phase_next;
    logic [NODE_W-1:0] a_idx_reg, a_idx_next;
    logic [FREQ_W-1:0] fa_hold_reg, fa_hold_next;
    logic [TOT_W-1:0]  p_reg, p_next;
    logic [DEP_W-1:0]  d_reg, d_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [LIMIT_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0]  span_reg, span_next;
    logic              err_reg, err_next;

    logic              fq_we;
    logic [NODE_W-1:0] fq_waddr, fq_ra, fq_rb;
    logic [FREQ_W-1:0] fq_wdata, fa_rd, fb_rd;
    logic              ch_we;
    logic [NODE_W-1:0] ch_waddr, ch_raddr;
    logic [2*NODE_W-1:0] ch_wdata, ch_rd;
    logic              lv_we;
    logic [NODE_W-1:0] lv_waddr, lv_raddr;
    logic [DEP_W-1:0]  lv_wdata, lv_rd;
    logic              sy_we;
    logic [SYM_W-1:0]  sy_waddr, sy_raddr, sy_wdata, sy_rd;

    logic              leaf_ok, par_ok, take_leaf;
    logic [NODE_W-1:0] pick_idx;
    logic [FREQ_W-1:0] pick_freq;
    logic [DEP_W-1:0]  lim_d, clip_d;
    logic [SUM_W-1:0]  full, clip_step, run_step;
    logic [LIMIT_W-1:0] run_shift;

    always_ff @(posedge clk)
    begin
        if (fq_we)
        begin
            freq_mem[fq_waddr] <= fq_wdata;
        end
        fa_rd <= freq_mem[fq_ra];
        fb_rd <= freq_mem[fq_rb];
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            child_mem[ch_waddr] <= ch_wdata;
        end
        ch_rd <= child_mem[ch_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lv_we)
        begin
            level_mem[lv_waddr] <= lv_wdata;
        end
        lv_rd <= level_mem[lv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sy_we)
        begin
            sym_mem[sy_waddr] <= sy_wdata;
        end
        sy_rd <= sym_mem[sy_raddr];
    end

    assign leaf_ok   = li_reg < n_reg;
    assign par_ok    = ti_reg < total_reg;
    assign take_leaf = leaf_ok && (!par_ok || fa_rd <= fb_rd);
    assign pick_idx  = take_leaf ? li_reg : ti_reg[NODE_W-1:0];
    assign pick_freq = take_leaf ? fa_rd : fb_rd;

    assign lim_d     = DEP_W'(lim_reg);
    assign clip_d    = (lv_rd > lim_d) ? lim_d : lv_rd;
    assign full      = SUM_W'(1) << lim_reg;
    assign clip_step = SUM_W'(1) << (lim_reg - clip_d[LIMIT_W-1:0]);
    // shift for the next deeper code in pass two, current depth in pass three
    assign run_shift = (state_reg == S_K2_RUN) ? (lim_reg - d_reg[LIMIT_W-1:0] - 4'd1)
                                               : (lim_reg - d_reg[LIMIT_W-1:0]);
    assign run_step  = SUM_W'(1) << run_shift;

    always_comb
    begin
        state_next   = state_reg;
        s_next       = s_reg;
        n_next       = n_reg;
        pos_next     = pos_reg;
        cur_c_next   = cur_c_reg;
        li_next      = li_reg;
        ti_next      = ti_reg;
        total_next   = total_reg;
        phase_next   = phase_reg;
        a_idx_next   = a_idx_reg;
        fa_hold_next = fa_hold_reg;
        p_next       = p_reg;
        d_next       = d_reg;
        sum_next     = sum_reg;
        i_next       = i_reg;
        lim_next     = lim_reg;
        span_next    = span_reg;
        err_next     = err_reg;

        fq_we    = 1'b0;
        fq_waddr = pos_reg;
        fq_wdata = FREQ_W'(cur_c_reg);
        fq_ra    = li_reg;
        fq_rb    = ti_reg[NODE_W-1:0];
        ch_we    = 1'b0;
        ch_waddr = total_reg[NODE_W-1:0];
        ch_wdata = {a_idx_reg, pick_idx};
        ch_raddr = p_reg[NODE_W-1:0];
        lv_we    = 1'b0;
        lv_waddr = i_reg;
        lv_wdata = d_reg;
        lv_raddr = i_reg;
        sy_we    = 1'b0;
        sy_waddr = pos_reg[SYM_W-1:0];
        sy_wdata = s_reg[SYM_W-1:0];
        sy_raddr = i_reg[SYM_W-1:0];
        len_we   = 1'b0;
        len_addr = sy_rd;
        len_data = lv_rd[LEN_W-1:0];
        result   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lim_next   = limit;
                    span_next  = span;
                    s_next     = '0;
                    n_next     = '0;
                    err_next   = 1'b0;
                    state_next = S_G_RD;
                end
            end
            S_G_RD:
            begin
                state_next = (s_reg == span_reg) ? S_T_INIT : S_G_CHK;
            end
            S_G_CHK:
            begin
                if (cnt_data == '0)
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = S_G_RD;
                end
                else
                begin
                    cur_c_next = cnt_data;
                    pos_next   = n_reg;
                    state_next = S_G_POS;
                end
            end
            S_G_POS:
            begin
                fq_ra    = pos_reg - 1'b1;
                sy_raddr = SYM_W'(pos_reg - 1'b1);
                if (pos_reg == '0)
                begin
                    fq_we      = 1'b1;
                    sy_we      = 1'b1;
                    n_next     = n_reg + 1'b1;
                    s_next     = s_reg + 1'b1;
                    state_next = S_G_RD;
                end
                else
                begin
                    state_next = S_G_CMP;
                end
            end
            S_G_CMP:
            begin
                fq_we = 1'b1;
                sy_we = 1'b1;
                if (fa_rd > FREQ_W'(cur_c_reg))
                begin
                    // shift the heavier leaf up one place
                    fq_wdata   = fa_rd;
                    sy_wdata   = sy_rd;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_G_POS;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    s_next     = s_reg + 1'b1;
                    state_next = S_G_RD;
                end
            end
            S_T_INIT:
            begin
                if (n_reg < CNT_W'(2))
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    li_next    = '0;
                    ti_next    = TOT_W'(n_reg);
                    total_next = TOT_W'(n_reg);
                    state_next = S_M_CHK;
                end
            end
            S_M_CHK:
            begin
                phase_next = 1'b0;
                if ((leaf_ok || (ti_reg + 1'b1 < total_reg))
                    && (total_reg < TOT_W'(NODE_SLOTS)))
                begin
                    state_next = S_M_RD;
                end
                else
                begin
                    state_next = S_D_ROOT;
                end
            end
            S_M_RD:
            begin
                state_next = S_M_PICK;
            end
            S_M_PICK:
            begin
                if (take_leaf)
                begin
                    li_next = li_reg + 1'b1;
                end
                else
                begin
                    ti_next = ti_reg + 1'b1;
                end
                if (!phase_reg)
                begin
                    a_idx_next   = pick_idx;
                    fa_hold_next = pick_freq;
                    phase_next   = 1'b1;
                    state_next   = S_M_RD;
                end
                else
                begin
                    fq_we      = 1'b1;
                    fq_waddr   = total_reg[NODE_W-1:0];
                    fq_wdata   = fa_hold_reg + pick_freq;
                    ch_we      = 1'b1;
                    total_next = total_reg + 1'b1;
                    state_next = S_M_CHK;
                end
            end
            S_D_ROOT:
            begin
                lv_we      = 1'b1;
                lv_waddr   = NODE_W'(total_reg - 1'b1);
                lv_wdata   = '0;
                p_next     = total_reg - 1'b1;
                state_next = S_D_RD;
            end
            S_D_RD:
            begin
                lv_raddr = p_reg[NODE_W-1:0];
                if (p_reg < TOT_W'(n_reg))
                begin
                    state_next = S_C_RD0;
                end
                else
                begin
                    state_next = S_D_W0;
                end
            end
            S_D_W0:
            begin
                lv_we      = 1'b1;
                lv_waddr   = ch_rd[2*NODE_W-1:NODE_W];
                lv_wdata   = lv_rd + 1'b1;
                d_next     = lv_rd + 1'b1;
                state_next = S_D_W1;
            end
            S_D_W1:
            begin
                lv_we      = 1'b1;
                lv_waddr   = ch_rd[NODE_W-1:0];
                p_next     = p_reg - 1'b1;
                state_next = S_D_RD;
            end
            S_C_RD0:
            begin
                lv_raddr   = '0;
                state_next = S_C_CHK0;
            end
            S_C_CHK0:
            begin
                i_next   = '0;
                sum_next = '0;
                state_next = (lv_rd > lim_d) ? S_K1_RD : S_O_RD;
            end
            S_K1_RD:
            begin
                if (i_reg == n_reg)
                begin
                    i_next     = '0;
                    state_next = S_K2_CHK;
                end
                else
                begin
                    state_next = S_K1_W;
                end
            end
            S_K1_W:
            begin
                lv_we      = 1'b1;
                lv_wdata   = clip_d;
                sum_next   = sum_reg + clip_step;
                i_next     = i_reg + 1'b1;
                state_next = S_K1_RD;
            end
            S_K2_CHK:
            begin
                if ((i_reg < n_reg) && (sum_reg >= full))
                begin
                    state_next = S_K2_LD;
                end
                else
                begin
                    i_next     = n_reg;
                    state_next = S_K3_RD;
                end
            end
            S_K2_LD:
            begin
                d_next     = lv_rd;
                state_next = S_K2_RUN;
            end
            S_K2_RUN:
            begin
                if (d_reg < lim_d)
                begin
                    d_next   = d_reg + 1'b1;
                    sum_next = sum_reg - run_step;
                end
                else
                begin
                    lv_we      = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_K2_CHK;
                end
            end
            S_K3_RD:
            begin
                lv_raddr = i_reg - 1'b1;
                if (i_reg == '0)
                begin
                    state_next = S_O_RD;
                end
                else
                begin
                    state_next = S_K3_LD;
                end
            end
            S_K3_LD:
            begin
                d_next     = lv_rd;
                state_next = S_K3_RUN;
            end
            S_K3_RUN:
            begin
                if ((d_reg > DEP_W'(1)) && (sum_reg + run_step < full))
                begin
                    d_next   = d_reg - 1'b1;
                    sum_next = sum_reg + run_step;
                end
                else
                begin
                    lv_we      = 1'b1;
                    lv_waddr   = i_reg - 1'b1;
                    i_next     = i_reg - 1'b1;
                    state_next = S_K3_RD;
                end
            end
            S_O_RD:
            begin
                state_next = (i_reg == n_reg) ? S_DONE : S_O_W;
            end
            S_O_W:
            begin
                len_we     = 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = S_O_RD;
            end
            S_DONE:
            begin
                result.done        = 1'b1;
                result.short_alpha = err_reg;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cnt_raddr = s_reg[SYM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            s_reg       <= '0;
            n_reg       <= '0;
            pos_reg     <= '0;
            li_reg      <= '0;
            ti_reg      <= '0;
            total_reg   <= '0;
            phase_reg   <= 1'b0;
            p_reg       <= '0;
            i_reg       <= '0;
            lim_reg     <= '0;
            span_reg    <= '0;
            err_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s_reg       <= s_next;
            n_reg       <= n_next;
            pos_reg     <= pos_next;
            li_reg      <= li_next;
            ti_reg      <= ti_next;
            total_reg   <= total_next;
            phase_reg   <= phase_next;
            p_reg       <= p_next;
            i_reg       <= i_next;
            lim_reg     <= lim_next;
            span_reg    <= span_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_c_reg   <= cur_c_next;
        a_idx_reg   <= a_idx_next;
        fa_hold_reg <= fa_hold_next;
        d_reg       <= d_next;
        sum_reg     <= sum_next;
    end

endmodule

// ===== design/huffman_code_length_builder_core.sv =====
// ---------------------------------------------------------------------------
// huffman_code_length_builder_core: length-limited Huffman code lengths
// Count table, length table, word handshake and the build sequencer.
// ---------------------------------------------------------------------------
// Write and read words take one cycle each and answer one cycle after they
// are accepted; a new word is taken while the previous answer is being
// collected. A build word holds the block until the sequencer is done; its
// run time grows with the alphabet size, the insertion shifts of the sort and
// the number n of used symbols, and with the length steps when the limit
// forces clamping, as the sequencer walks its single-write scratch memories
// one access per cycle. No reset clearing pass is needed: count and length
// entries carry valid bits.
module huffman_code_length_builder_core #(
    parameter int MAX_SYMBOLS   = hclb_pkg::DEF_MAX_SYMBOLS,
    parameter int COUNT_BITS    = hclb_pkg::DEF_COUNT_BITS,
    parameter int DEFAULT_LIMIT = hclb_pkg::DEF_LIMIT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [hclb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hclb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hclb_pkg::ACTION_W-1:0]     action,
    input  logic [hclb_pkg::SYMBOL_W-1:0]     symbol,
    input  logic [hclb_pkg::COUNT_W-1:0]      count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              status,
    output logic [hclb_pkg::LEN_W-1:0]        code_len
);
    import hclb_pkg::*;

    localparam int SYM_W  = $clog2(MAX_SYMBOLS);
    localparam int CW     = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int SPAN_W = SYM_W + 1;

    logic [LIMIT_W-1:0] limit_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    logic [CW-1:0]    cnt_mem [MAX_SYMBOLS];
    logic [LEN_W-1:0] len_mem [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] cnt_vld_reg;
    logic [MAX_SYMBOLS-1:0] len_vld_reg;

    logic             accept, in_range, take_out;
    logic [SYM_W-1:0] sym_idx;
    logic             build_busy_reg;
    logic             out_valid_reg, status_reg, len_sel_reg, len_hit_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic [CW-1:0]    cnt_rd_reg;
    logic             cnt_hit_reg;

    logic [LIMIT_W-1:0] eff_limit;
    logic [SPAN_W-1:0]  span;
    logic [SYM_W-1:0]   cnt_raddr, len_addr;
    logic               len_we;
    logic [LEN_W-1:0]   len_data;
    hclb_result_t       eng_res;

    assign take_out = out_valid_reg && !out_stall;
    assign in_stall = build_busy_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign sym_idx  = SYM_W'(symbol);
    assign in_range = 32'(symbol) < MAX_SYMBOLS;

    assign eff_limit = (limit_reg == '0) ? LIMIT_W'(DEFAULT_LIMIT) : limit_reg;
    assign span      = (32'(alpha_reg) > MAX_SYMBOLS) ? SPAN_W'(MAX_SYMBOLS)
                                                      : SPAN_W'(alpha_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                default:   limit_reg <= limit_reg;
            endcase
        end
    end

    // count table: written by words, read by the sequencer
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_WRITE && in_range)
        begin
            cnt_mem[sym_idx] <= count[CW-1:0];
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    // length table: written by the sequencer, read by words
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_addr] <= len_data;
        end
        if (accept)
        begin
            len_rd_reg <= len_mem[sym_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg    <= '0;
            len_vld_reg    <= '0;
            cnt_hit_reg    <= 1'b0;
            len_hit_reg    <= 1'b0;
            len_sel_reg    <= 1'b0;
            build_busy_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= 1'b0;
        end
        else
        begin
            cnt_hit_reg <= cnt_vld_reg[cnt_raddr];
            if (accept && action == ACT_WRITE && in_range)
            begin
                cnt_vld_reg[sym_idx] <= 1'b1;
            end
            // a build drops every stored length at once
            if (accept && action == ACT_BUILD)
            begin
                len_vld_reg <= '0;
            end
            else if (len_we)
            begin
                len_vld_reg[len_addr] <= 1'b1;
            end

            if (take_out)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                len_hit_reg <= len_vld_reg[sym_idx];
                len_sel_reg <= (action == ACT_READ) && in_range;
                status_reg  <= 1'b0;
                if (action == ACT_BUILD)
                begin
                    build_busy_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (eng_res.done)
            begin
                build_busy_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
                status_reg     <= eng_res.short_alpha;
            end
        end
    end

    hclb_engine #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && action == ACT_BUILD),
        .limit     (eff_limit),
        .span      (span),
        .cnt_raddr (cnt_raddr),
        .cnt_data  (cnt_hit_reg ? cnt_rd_reg : '0),
        .len_we    (len_we),
        .len_addr  (len_addr),
        .len_data  (len_data),
        .result    (eng_res)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign code_len  = (len_sel_reg && len_hit_reg) ? len_rd_reg : '0;

`ifndef SYNTHESIS
    a_done_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res.done |-> build_busy_reg)
        else $error("build finished while no build was running");

    a_build_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_BUILD) |=> (build_busy_reg && !out_valid))
        else $error("build word answered before the build ran");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        build_busy_reg |-> in_stall)
        else $error("input taken during a build");

    a_done_answers: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res.done |=> (out_valid && !build_busy_reg))
        else $error("finished build left no answer");
`endif

endmodule
